@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int HEX_W  = 32;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int OCOL_W = 7;
	localparam int OROW_W = 5;
	localparam int ATTR_W = 8;
	localparam int NIB_W  = 4;
	localparam int STEP_W = 4;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUT_BYTE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUT_WORD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	localparam int TAB_STEP = 8;

	localparam logic [STEP_W-1:0] STEP_PREFIX_0 = 4'd0;
	localparam logic [STEP_W-1:0] STEP_PREFIX_X = 4'd1;
	localparam logic [STEP_W-1:0] LAST_STEP_ONE  = 4'd0;
	localparam logic [STEP_W-1:0] LAST_STEP_BYTE = 4'd3;
	localparam logic [STEP_W-1:0] LAST_STEP_WORD = 4'd9;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic                last;
		logic [CHAR_W-1:0]   code;
		logic [IDX_W-1:0]    index;
	} op_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + ext;
		end
		return CH_UPA + ext - 8'd10;
	endfunction

endpackage

@@ rtl/tcw_req_if.sv @@
interface tcw_req_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_code;
	logic [HEX_W-1:0]  hex_value;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, command, char_code, hex_value, cell_index, input ready);
	modport sink (input valid, command, char_code, hex_value, cell_index, output ready);
endinterface

@@ rtl/tcw_rsp_if.sv @@
interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_data;
	logic [OCOL_W-1:0] cursor_column;
	logic [OROW_W-1:0] cursor_row;

	modport source (output valid, cell_data, cursor_column, cursor_row, input ready);
	modport sink (input valid, cell_data, cursor_column, cursor_row, output ready);
endinterface

@@ rtl/tcw_ram.sv @@
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tcw_front.sv @@
module tcw_front import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run,
	tcw_req_if.sink   req,
	output logic      push,
	output op_t       push_op,
	input  logic      full
);

	logic              pend_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] code_q;
	logic [IDX_W-1:0]  idx_q;
	logic [HEX_W-1:0]  val_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] last_step_q;

	assign req.ready = run && !pend_q;
	assign push      = pend_q && !full;

	always_comb begin
		push_op.index = idx_q;
		push_op.code  = code_q;
		push_op.last  = (step_q == last_step_q);
		case (cmd_q)
			CMD_PUT_CHAR: begin
				push_op.kind = OP_CHAR;
			end
			CMD_PUT_BYTE, CMD_PUT_WORD: begin
				push_op.kind = OP_CHAR;
				if (step_q == STEP_PREFIX_0) begin
					push_op.code = CH_ZERO;
				end else if (step_q == STEP_PREFIX_X) begin
					push_op.code = CH_X;
				end else begin
					push_op.code = hex_char(val_q[HEX_W-1 -: NIB_W]);
				end
			end
			CMD_CLEAR: begin
				push_op.kind = OP_CLEAR;
			end
			CMD_READ: begin
				push_op.kind = OP_READ;
			end
			default: begin
				push_op.kind = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			pend_q      <= 1'b1;
			cmd_q       <= req.command;
			code_q      <= req.char_code;
			idx_q       <= req.cell_index;
			step_q      <= '0;
			if (req.command == CMD_PUT_BYTE) begin
				val_q       <= {req.hex_value[CHAR_W-1:0], {(HEX_W-CHAR_W){1'b0}}};
				last_step_q <= LAST_STEP_BYTE;
			end else if (req.command == CMD_PUT_WORD) begin
				val_q       <= req.hex_value;
				last_step_q <= LAST_STEP_WORD;
			end else begin
				val_q       <= req.hex_value;
				last_step_q <= LAST_STEP_ONE;
			end
		end else if (push) begin
			if (push_op.last) begin
				pend_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
				if (step_q > STEP_PREFIX_X) begin
					val_q <= {val_q[HEX_W-NIB_W-1:0], {NIB_W{1'b0}}};
				end
			end
		end
	end

endmodule

@@ rtl/tcw_queue.sv @@
module tcw_queue import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic empty,
	output op_t  pop_op
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

endmodule

@@ rtl/tcw_back.sv @@
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  op_t               q_op,
	output logic              run,
	tcw_rsp_if.source         rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS + 1);
	localparam int AW    = $clog2(CELLS);
	localparam int OFF_W = $clog2(CELLS + 1);
	localparam int SUM_W = ((OFF_W > IDX_W) ? OFF_W : IDX_W) + 1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_SCROLL,
		S_CLEAR,
		S_READ,
		S_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [CELL_W-1:0] cell_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [OFF_W-1:0]  row_off_q;
	logic [OFF_W-1:0]  base_off_q;
	logic [OFF_W-1:0]  sweep_q;
	logic [ATTR_W-1:0] attr_q;
	logic              out_valid_q;
	logic [CELL_W-1:0] out_cell_q;
	logic [OCOL_W-1:0] out_col_q;
	logic [OROW_W-1:0] out_row_q;

	logic [SUM_W-1:0]  char_sum;
	logic [SUM_W-1:0]  char_addr;
	logic [SUM_W-1:0]  rd_sum;
	logic [SUM_W-1:0]  rd_addr;
	logic [SUM_W-1:0]  base_sum;
	logic              rd_in_range;
	logic              printable;
	logic [COL_W:0]    col_inc;
	logic [COL_W:0]    tab_col;
	logic [SUM_W-1:0]  wr_addr;
	logic              ram_we;
	logic              ram_re;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	assign char_sum  = SUM_W'(base_off_q) + SUM_W'(row_off_q) + SUM_W'(col_q);
	assign char_addr = (char_sum >= SUM_W'(CELLS)) ? char_sum - SUM_W'(CELLS) : char_sum;
	assign rd_sum    = SUM_W'(op_q.index) + SUM_W'(base_off_q);
	assign rd_addr   = (rd_sum >= SUM_W'(CELLS)) ? rd_sum - SUM_W'(CELLS) : rd_sum;
	assign base_sum  = SUM_W'(base_off_q) + SUM_W'(COLUMNS);
	assign rd_in_range = SUM_W'(op_q.index) < SUM_W'(CELLS);
	assign printable = !(op_q.code inside {CH_NUL, CH_BS, CH_TAB, CH_LF, CH_CR});
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign tab_col   = ({1'b0, col_q} + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign run   = (state_q != S_INIT);

	assign rsp.valid         = out_valid_q;
	assign rsp.cell_data     = out_cell_q;
	assign rsp.cursor_column = out_col_q;
	assign rsp.cursor_row    = out_row_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		wr_addr   = SUM_W'(sweep_q);
		ram_wdata = {attr_q, CH_SPACE};
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {ATTR_RESET, CH_SPACE};
			end
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_SCROLL: begin
				ram_we  = 1'b1;
				wr_addr = SUM_W'(base_off_q) + SUM_W'(sweep_q);
			end
			S_EXEC: begin
				if (op_q.kind == OP_CHAR && printable && row_q != ROW_W'(ROWS)) begin
					ram_we    = 1'b1;
					wr_addr   = char_addr;
					ram_wdata = {attr_q, op_q.code};
				end
				if (op_q.kind == OP_READ && rd_in_range) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_q       <= '0;
			row_off_q   <= '0;
			base_off_q  <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == OFF_W'(CELLS - 1)) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						op_q    <= q_op;
						cell_q  <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= op_q.last ? S_DONE : S_IDLE;
					case (op_q.kind)
						OP_CHAR: begin
							if (op_q.code == CH_NUL) begin
							end else if (row_q == ROW_W'(ROWS)) begin
								state_q <= S_SCROLL;
							end else begin
								case (op_q.code)
									CH_BS: begin
										if (col_q != '0) begin
											col_q <= col_q - 1'b1;
										end
									end
									CH_TAB: begin
										if (tab_col >= (COL_W+1)'(COLUMNS)) begin
											col_q     <= '0;
											row_q     <= row_q + 1'b1;
											row_off_q <= row_off_q + OFF_W'(COLUMNS);
										end else begin
											col_q <= tab_col[COL_W-1:0];
										end
									end
									CH_LF: begin
										col_q     <= '0;
										row_q     <= row_q + 1'b1;
										row_off_q <= row_off_q + OFF_W'(COLUMNS);
									end
									CH_CR: begin
										col_q <= '0;
									end
									default: begin
										if (col_inc >= (COL_W+1)'(COLUMNS)) begin
											col_q     <= '0;
											row_q     <= row_q + 1'b1;
											row_off_q <= row_off_q + OFF_W'(COLUMNS);
										end else begin
											col_q <= col_inc[COL_W-1:0];
										end
									end
								endcase
							end
						end
						OP_CLEAR: begin
							state_q <= S_CLEAR;
						end
						OP_READ: begin
							if (rd_in_range) begin
								state_q <= S_READ;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCROLL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == OFF_W'(COLUMNS - 1)) begin
						sweep_q    <= '0;
						base_off_q <= (base_sum >= SUM_W'(CELLS)) ? '0 : base_sum[OFF_W-1:0];
						row_q      <= ROW_W'(ROWS - 1);
						row_off_q  <= OFF_W'((ROWS - 1) * COLUMNS);
						state_q    <= S_EXEC;
					end
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == OFF_W'(CELLS - 1)) begin
						sweep_q   <= '0;
						col_q     <= '0;
						row_q     <= '0;
						row_off_q <= '0;
						state_q   <= op_q.last ? S_DONE : S_IDLE;
					end
				end
				S_READ: begin
					cell_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_cell_q  <= cell_q;
						out_col_q   <= OCOL_W'(col_q);
						out_row_q   <= OROW_W'(row_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) row_q <= ROW_W'(ROWS))
		else $error("cursor row beyond scroll point");
	assert property (@(posedge clk) disable iff (!arst_n) col_q < COL_W'(COLUMNS - 1) ||
		col_q == COL_W'(COLUMNS - 1))
		else $error("cursor column beyond row end");
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> wr_addr < SUM_W'(CELLS))
		else $error("screen write out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL) |-> row_q == ROW_W'(ROWS))
		else $error("scroll without pending row");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q.kind == OP_CHAR && printable && row_q != ROW_W'(ROWS))
		|-> SUM_W'(row_off_q) == SUM_W'(row_q) * SUM_W'(COLUMNS))
		else $error("row offset out of step with cursor row");

endmodule

@@ rtl/text_console_writer.sv @@
// Text console: a screen of COLUMNS x ROWS cells (attribute high byte, character low
// byte) with a cursor. Each command beat on req returns exactly one beat on rsp with
// the cursor after the command and, for a cell read, the cell contents. The front end
// expands hex commands into characters ("0x" and 2 or 8 digits) and queues them for
// the back end, which dequeues each character, then executes it, and registers the
// result of a command after its last character. The screen is a single-port-write RAM
// kept as a ring of rows, so a scroll rewrites only the new bottom row and a clear
// writes every cell. After reset the block blanks every cell of the RAM and holds
// req.ready low until done. The attribute register may be written at any time the
// block is idle and applies to later writes and blank cells.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ATTR_W-1:0] cfg_wr_data,
	tcw_req_if.sink           req,
	tcw_rsp_if.source         rsp
);

	logic run;
	logic push;
	logic full;
	logic pop;
	logic empty;
	op_t  push_op;
	op_t  pop_op;

	tcw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.run     (run),
		.req     (req),
		.push    (push),
		.push_op (push_op),
		.full    (full)
	);

	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.pop_op  (pop_op)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (empty),
		.q_pop       (pop),
		.q_op        (pop_op),
		.run         (run),
		.rsp         (rsp)
	);

endmodule
